>>> sv/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int TIME_BITS_DEF = 48;

	localparam logic [15:0] COALESCE_RESET = 16'd100;

	localparam logic [1:0] OP_SUBMIT = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	localparam logic [2:0] ST_FIRED     = 3'd0;
	localparam logic [2:0] ST_ARMED     = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_IGNORED   = 3'd3;
	localparam logic [2:0] ST_NOTHING   = 3'd4;
	localparam logic [2:0] ST_ABORTED   = 3'd5;

	localparam logic REG_COALESCE = 1'b0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  handle;
		logic [47:0] deadline;
		logic [47:0] now;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  result_handle;
		logic [47:0] next_deadline;
		logic        last;
	} out_item_t;

	// Command broadcast to every cell of the sorted chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

>>> sv/deadline_timer_queue.sv
// Top level of the deadline timer queue: sequencer, armed map and cell chain.
`timescale 1ns / 1ps
// Timers sit in a chain of SLOTS cells kept sorted by deadline, then handle,
// with the earliest timer in the first cell. A submit or cancel moves through
// the execute and response states to one result. A tick or flush gives one
// result per timer fired or aborted, or one if none is due; each step is one
// shift of the cell chain plus one output register load. A new input is taken
// only after the last result of the previous one is in the output register.
// Configuration is an APB register at paddr[2] low (coalescing window, reset 100).
module deadline_timer_queue #(
	parameter int SLOTS     = dtq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dtq_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output dtq_pkg::out_item_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import dtq_pkg::*;

	localparam int HW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TB = TIME_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t          state_q;
	logic [1:0]      op_q;
	logic [5:0]      hd_q;
	logic [TB-1:0]   dl_q;
	logic [TB-1:0]   limit_q;
	logic [2:0]      res_status_q;
	logic [5:0]      res_hd_q;
	logic [15:0]     coalesce_q;
	logic [SLOTS-1:0] armed_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic            in_xfer, load_out, in_range, hd_armed, is_drain, due, pop, last_w;
	logic [TB:0]     sum;
	logic [TB-1:0]   now_t;
	cell_cmd_t       cmd;
	logic [HW-1:0]   rem_hd;

	logic [SLOTS-1:0] cv;
	logic [TB-1:0]   cdl [SLOTS];
	logic [HW-1:0]   chd [SLOTS];
	logic            cbefore [SLOTS];
	logic            cgone [SLOTS];

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COALESCE) ? {16'd0, coalesce_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coalesce_q <= COALESCE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_COALESCE) begin
			coalesce_q <= pwdata[15:0];
		end
	end

	// Input transfer and saturating fire limit
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign now_t    = TB'(in_data.now);
	assign sum      = {1'b0, now_t} + (TB + 1)'(coalesce_q);

	// Decode against the armed map and the head of the chain
	assign in_range = ({1'b0, hd_q} < 7'(SLOTS));
	assign hd_armed = in_range && armed_q[hd_q[HW-1:0]];
	assign is_drain = (op_q == OP_TICK) || (op_q == OP_FLUSH);
	assign due      = cv[0] && ((op_q == OP_FLUSH) || (cdl[0] <= limit_q));
	assign pop      = (state_q == S_EXEC) && is_drain && due;

	assign cmd.ins = (state_q == S_EXEC) && (op_q == OP_SUBMIT) && in_range && !hd_armed;
	assign cmd.rem = ((state_q == S_EXEC) && (op_q == OP_CANCEL) && hd_armed) || pop;
	assign rem_hd  = (op_q == OP_CANCEL) ? hd_q[HW-1:0] : chd[0];

	// Cell chain
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic          pv, pb, pg, nv;
		logic [TB-1:0] pdl, ndl;
		logic [HW-1:0] phd, nhd;
		if (i == 0) begin : g_first
			assign pv = 1'b0;
			assign pdl = '0;
			assign phd = '0;
			assign pb = 1'b0;
			assign pg = 1'b0;
		end else begin : g_mid
			assign pv = cv[i-1];
			assign pdl = cdl[i-1];
			assign phd = chd[i-1];
			assign pb = cbefore[i-1];
			assign pg = cgone[i-1];
		end
		if (i == SLOTS - 1) begin : g_tail
			assign nv = 1'b0;
			assign ndl = '0;
			assign nhd = '0;
		end else begin : g_inner
			assign nv = cv[i+1];
			assign ndl = cdl[i+1];
			assign nhd = chd[i+1];
		end
		dtq_cell #(.TB(TB), .HW(HW)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.new_dl(dl_q), .new_hd(hd_q[HW-1:0]), .rem_hd(rem_hd),
			.prev_v(pv), .prev_dl(pdl), .prev_hd(phd), .prev_before(pb), .prev_gone(pg),
			.next_v(nv), .next_dl(ndl), .next_hd(nhd),
			.valid_q(cv[i]), .dl_q(cdl[i]), .hd_q(chd[i]),
			.ahead(cbefore[i]), .gone(cgone[i])
		);
	end

	// Result is final unless another timer is due
	assign last_w   = !(is_drain && (res_status_q != ST_NOTHING) && due);
	assign load_out = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			armed_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.ins) armed_q[hd_q[HW-1:0]] <= 1'b1;
					if (cmd.rem) armed_q[rem_hd] <= 1'b0;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) state_q <= last_w ? S_IDLE : S_EXEC;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold item fields and pending status
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= in_data.operation;
			hd_q    <= in_data.handle;
			dl_q    <= TB'(in_data.deadline);
			limit_q <= sum[TB] ? '1 : sum[TB-1:0];
		end
		if (state_q == S_EXEC) begin
			res_hd_q <= hd_q;
			case (op_q)
				OP_SUBMIT: res_status_q <= cmd.ins ? ST_ARMED : ST_IGNORED;
				OP_CANCEL: res_status_q <= cmd.rem ? ST_CANCELLED : ST_IGNORED;
				OP_TICK:   res_status_q <= pop ? ST_FIRED : ST_NOTHING;
				default:   res_status_q <= pop ? ST_ABORTED : ST_NOTHING;
			endcase
			if (is_drain) res_hd_q <= pop ? 6'(chd[0]) : 6'd0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status        <= res_status_q;
			out_q.result_handle <= res_hd_q;
			out_q.next_deadline <= cv[0] ? 48'(cdl[0]) : '1;
			out_q.last          <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(armed_q) == $countones(cv))
		else $error("armed map and chain occupancy disagree");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(cv & (cv + SLOTS'(1))) == '0)
		else $error("chain has a hole");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> (state_q != S_IDLE))
		else $error("item finished before its last result");

endmodule

>>> sv/dtq_cell.sv
// One cell of the sorted timer chain: holds one timer, shifts with its neighbors.
`timescale 1ns / 1ps
module dtq_cell #(
	parameter int TB = dtq_pkg::TIME_BITS_DEF,
	parameter int HW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtq_pkg::cell_cmd_t cmd,
	input  logic [TB-1:0]     new_dl,
	input  logic [HW-1:0]     new_hd,
	input  logic [HW-1:0]     rem_hd,
	input  logic              prev_v,
	input  logic [TB-1:0]     prev_dl,
	input  logic [HW-1:0]     prev_hd,
	input  logic              prev_before,
	input  logic              prev_gone,
	input  logic              next_v,
	input  logic [TB-1:0]     next_dl,
	input  logic [HW-1:0]     next_hd,
	output logic              valid_q,
	output logic [TB-1:0]     dl_q,
	output logic [HW-1:0]     hd_q,
	output logic              ahead,
	output logic              gone
);
	import dtq_pkg::*;

	logic take_prev, take_new, take_next;

	// New key sorts ahead of this cell's timer, or the cell is empty
	assign ahead = !valid_q || (new_dl < dl_q) || ((new_dl == dl_q) && (new_hd < hd_q));
	// Removal point lies at or ahead of this cell
	assign gone = prev_gone || (valid_q && (hd_q == rem_hd));

	assign take_prev = cmd.ins && ahead && prev_before;
	assign take_new  = cmd.ins && ahead && !prev_before;
	assign take_next = !cmd.ins && cmd.rem && gone;

	// Advance occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev_v;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_next) begin
			valid_q <= next_v;
		end
	end

	// Shift timer payload
	always_ff @(posedge clk) begin
		if (take_prev) begin
			dl_q <= prev_dl;
			hd_q <= prev_hd;
		end else if (take_new) begin
			dl_q <= new_dl;
			hd_q <= new_hd;
		end else if (take_next) begin
			dl_q <= next_dl;
			hd_q <= next_hd;
		end
	end

endmodule
